FILE: hw/rtl/glu_pkg.sv
// glu_pkg: shared constants, sequencer states and control structs for gcd_lcm_unit.
// No dependencies; compiled first.
`default_nettype none

package glu_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;  // default operand width
    localparam int GCD_WIDTH         = 16;  // gcd_value field width
    localparam int LCM_WIDTH         = 32;  // lcm_value field width

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } t_state;

    // top level -> engine
    typedef struct packed {
        logic start;  // operand transaction accepted this cycle
        logic take;   // finished result moves to the output register
    } t_eng_ctl;

    // engine -> top level
    typedef struct packed {
        logic idle;   // free to take a new operand pair
        logic done;   // result is held and waiting to be taken
    } t_eng_sts;

endpackage

`default_nettype wire

FILE: hw/rtl/glu_if.sv
// glu_in_if / glu_out_if: valid-ready channels of gcd_lcm_unit.
// Depends on glu_pkg for the default operand width and the result field widths.
`default_nettype none

interface glu_in_if #(
    parameter int OPERAND_WIDTH = glu_pkg::OPERAND_WIDTH_DEF
);
    logic                     valid;
    logic                     ready;
    logic [OPERAND_WIDTH-1:0] operand_a;
    logic [OPERAND_WIDTH-1:0] operand_b;

    modport source (output valid, output operand_a, output operand_b, input ready);
    modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface glu_out_if;
    logic                           valid;
    logic                           ready;
    logic [glu_pkg::GCD_WIDTH-1:0]  gcd_value;
    logic [glu_pkg::LCM_WIDTH-1:0]  lcm_value;
    logic                           invalid;

    modport source (output valid, output gcd_value, output lcm_value, output invalid,
                    input ready);
    modport sink   (input valid, input gcd_value, input lcm_value, input invalid,
                    output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/glu_engine.sv
// glu_engine: sequencer and shared shift/compare/subtract-add datapath.
// Binary GCD, restoring division a/g, then shift-add multiply (a/g)*b.
// Depends on glu_pkg.
`default_nettype none

module glu_engine #(
    parameter int OPERAND_WIDTH = glu_pkg::OPERAND_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire glu_pkg::t_eng_ctl               i_ctl,
    input  wire logic [OPERAND_WIDTH-1:0]        i_a,
    input  wire logic [OPERAND_WIDTH-1:0]        i_b,
    output glu_pkg::t_eng_sts                    o_sts,
    output logic [glu_pkg::GCD_WIDTH-1:0]        o_gcd,
    output logic [glu_pkg::LCM_WIDTH-1:0]        o_lcm,
    output logic                                 o_invalid
);
    import glu_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(W);

    t_state          r_state, n_state;
    logic [W-1:0]    r_a, n_a;
    logic [W-1:0]    r_b, n_b;
    logic [W-1:0]    r_x, n_x;
    logic [W-1:0]    r_y, n_y;
    logic [CW-1:0]   r_k, n_k;
    logic [W-1:0]    r_g, n_g;
    logic [W-1:0]    r_q, n_q;
    logic [W-1:0]    r_rem, n_rem;
    logic [2*W-1:0]  r_prod, n_prod;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_inv, n_inv;

    // shared unit operands
    logic            x_gt_y;
    logic [W-1:0]    diff;
    logic [W:0]      trial;
    logic            ge;
    logic [2*W-1:0]  addend;

    logic [GCD_WIDTH+W-1:0]   gcd_ext;
    logic [LCM_WIDTH+2*W-1:0] lcm_ext;

    always_comb begin
        x_gt_y = r_x > r_y;
        diff   = x_gt_y ? (r_x - r_y) : (r_y - r_x);
        trial  = {r_rem, r_q[W-1]};
        ge     = trial >= {1'b0, r_g};
        addend = r_b[W-1] ? {{W{1'b0}}, r_q} : '0;
    end

    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        n_x     = r_x;
        n_y     = r_y;
        n_k     = r_k;
        n_g     = r_g;
        n_q     = r_q;
        n_rem   = r_rem;
        n_prod  = r_prod;
        n_cnt   = r_cnt;
        n_inv   = r_inv;
        case (r_state)
            ST_IDLE: begin
                if (i_ctl.start) begin
                    n_a = i_a;
                    n_b = i_b;
                    n_x = i_a;
                    n_y = i_b;
                    n_k = '0;
                    if (i_a == '0 || i_b == '0) begin
                        n_inv   = 1'b1;
                        n_g     = '0;
                        n_prod  = '0;
                        n_state = ST_DONE;
                    end else begin
                        n_inv   = 1'b0;
                        n_state = ST_GCD;
                    end
                end
            end
            ST_GCD: begin
                if (r_x == r_y) begin
                    n_g     = r_x << r_k;
                    n_q     = r_a;
                    n_rem   = '0;
                    n_cnt   = CW'(W - 1);
                    n_state = ST_DIV;
                end else if (!r_x[0] && !r_y[0]) begin
                    n_x = r_x >> 1;
                    n_y = r_y >> 1;
                    n_k = r_k + 1'b1;
                end else if (!r_x[0]) begin
                    n_x = r_x >> 1;
                end else if (!r_y[0]) begin
                    n_y = r_y >> 1;
                end else if (x_gt_y) begin
                    n_x = diff >> 1;
                end else begin
                    n_y = diff >> 1;
                end
            end
            ST_DIV: begin
                // one quotient bit per cycle; dividend shifts out of r_q
                n_rem = ge ? W'(trial - {1'b0, r_g}) : trial[W-1:0];
                n_q   = {r_q[W-2:0], ge};
                if (r_cnt == '0) begin
                    n_cnt   = CW'(W - 1);
                    n_prod  = '0;
                    n_state = ST_MUL;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_MUL: begin
                // MSB-first shift-add of quotient times b
                n_prod = {r_prod[2*W-2:0], 1'b0} + addend;
                n_b    = r_b << 1;
                if (r_cnt == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_DONE: begin
                if (i_ctl.take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_b    <= n_b;
        r_x    <= n_x;
        r_y    <= n_y;
        r_k    <= n_k;
        r_g    <= n_g;
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_prod <= n_prod;
        r_cnt  <= n_cnt;
        r_inv  <= n_inv;
    end

    // fit results to the fixed field widths (zero-extend or truncate)
    always_comb begin
        gcd_ext    = {{GCD_WIDTH{1'b0}}, r_g};
        lcm_ext    = {{LCM_WIDTH{1'b0}}, r_prod};
        o_gcd      = gcd_ext[GCD_WIDTH-1:0];
        o_lcm      = lcm_ext[LCM_WIDTH-1:0];
        o_invalid  = r_inv;
        o_sts.idle = (r_state == ST_IDLE);
        o_sts.done = (r_state == ST_DONE);
    end

endmodule

`default_nettype wire

FILE: hw/rtl/gcd_lcm_unit.sv
// gcd_lcm_unit: greatest common divisor and least common multiple of two operands.
// Steps: binary GCD, restoring division a/g, shift-add multiply (a/g)*b. When an operand
//   is zero, the engine skips to the done state and flags the result invalid.
// New pairs are taken only while the engine is idle; it stalls while waiting on the output.
// Reset (i_rst_n, synchronous, active low) idles the sequencer and empties the output
//   register; payload registers are not reset.
`default_nettype none

module gcd_lcm_unit #(
    parameter int OPERAND_WIDTH = glu_pkg::OPERAND_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    glu_in_if.sink     i_op,
    glu_out_if.source  o_res
);
    import glu_pkg::*;

    t_eng_ctl                eng_ctl;
    t_eng_sts                eng_sts;
    logic [GCD_WIDTH-1:0]    eng_gcd;
    logic [LCM_WIDTH-1:0]    eng_lcm;
    logic                    eng_inv;

    // output register: parts the engine from the consumer
    logic                    r_valid, n_valid;
    logic [GCD_WIDTH-1:0]    r_gcd;
    logic [LCM_WIDTH-1:0]    r_lcm;
    logic                    r_inv;

    // A new operand transaction is taken whenever the engine is idle, even while
    // the previous result still waits in the output register.
    assign i_op.ready    = eng_sts.idle;
    assign eng_ctl.start = i_op.valid && eng_sts.idle;

    // Engine result moves out when the output register is empty or draining.
    assign eng_ctl.take  = eng_sts.done && (!r_valid || o_res.ready);

    glu_engine #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (eng_ctl),
        .i_a       (i_op.operand_a),
        .i_b       (i_op.operand_b),
        .o_sts     (eng_sts),
        .o_gcd     (eng_gcd),
        .o_lcm     (eng_lcm),
        .o_invalid (eng_inv)
    );

    always_comb begin
        n_valid = r_valid;
        if (eng_ctl.take) begin
            n_valid = 1'b1;
        end else if (o_res.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_ctl.take) begin
            r_gcd <= eng_gcd;
            r_lcm <= eng_lcm;
            r_inv <= eng_inv;
        end
    end

    assign o_res.valid     = r_valid;
    assign o_res.gcd_value = r_gcd;
    assign o_res.lcm_value = r_lcm;
    assign o_res.invalid   = r_inv;

endmodule

`default_nettype wire
